@@ sv/scq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_pkg
// Shared types, constants and helpers of the timed command scheduler queue.
// ----------------------------------------------------------------------------
package scq_pkg;

  localparam int DEPTH             = 8;
  localparam int MAX_MESSAGE_BYTES = 256;
  localparam int MAX_PER_STEP      = 8;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = $clog2(MAX_PER_STEP + 1);

  localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(DEPTH);

  typedef enum logic [1:0] {
    ACT_SUBMIT  = 2'd0,
    ACT_SERVICE = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OC_ACCEPTED = 3'd0,
    OC_FULL     = 3'd1,
    OC_BAD      = 3'd2,
    OC_NOW      = 3'd3,
    OC_DISPATCH = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_SVC_RD,
    S_SVC_CMP
  } state_e;

  typedef struct packed {
    logic [63:0] due;
    logic [31:0] tag;
    logic [15:0] bytes;
  } entry_t;

  typedef struct packed {
    logic        valid;
    outcome_e    outcome;
    logic [31:0] tag;
    logic [15:0] bytes;
    logic [63:0] due;
    logic        last;
  } result_t;

  // Physical slot of logical position off behind base, modulo DEPTH.
  function automatic logic [IDX_W-1:0] wrap_idx(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ sv/scq_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq interfaces
// Valid/ready channels for command requests and scheduler results.
// ----------------------------------------------------------------------------
interface scq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] time_now;
  logic [63:0] due_time;
  logic [31:0] command_tag;
  logic [15:0] command_bytes;

  modport source (output valid, action, time_now, due_time, command_tag,
                  command_bytes, input ready);
  modport sink (input valid, action, time_now, due_time, command_tag,
                command_bytes, output ready);
endinterface

interface scq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [31:0] out_tag;
  logic [15:0] out_bytes;
  logic [63:0] out_due_time;
  logic        last_of_run;

  modport source (output valid, outcome, out_tag, out_bytes, out_due_time,
                  last_of_run, input ready);
  modport sink (input valid, outcome, out_tag, out_bytes, out_due_time,
                last_of_run, output ready);
endinterface

@@ sv/scq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scq_core
// Sequencer, entry ring and shared 64-bit comparator of the scheduler queue.
// ----------------------------------------------------------------------------
module scq_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  scq_in_if.sink           in_i,
  input  logic             out_free_i,
  output scq_pkg::result_t emit_o
);
  import scq_pkg::*;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      pos_q, pos_d;
  logic [STEP_W-1:0]     n_q, n_d;
  logic                  pend_q, pend_d;
  entry_t                pend_ent_q, pend_ent_d;

  logic [63:0]           now_q, due_q;
  logic [31:0]           tag_q;
  logic [15:0]           bytes_q;

  entry_t                mem_q [DEPTH];
  entry_t                rd_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_data;

  logic [63:0]           cmp_a, cmp_b;
  logic                  cmp_le;
  logic                  in_fire;
  logic                  due_hit, ins_stop, chk_now, chk_bad, chk_full, chk_done;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  // Shared comparator
  always_comb begin
    unique case (state_q)
      S_CHECK: begin
        cmp_a = due_q;
        cmp_b = now_q;
      end
      S_INS_CMP: begin
        cmp_a = rd_q.due;
        cmp_b = due_q;
      end
      default: begin
        cmp_a = rd_q.due;
        cmp_b = now_q;
      end
    endcase
  end
  assign cmp_le = (cmp_a <= cmp_b);

  assign chk_now  = (due_q == 64'd0) || cmp_le;
  assign chk_bad  = (bytes_q > 16'(MAX_MESSAGE_BYTES));
  assign chk_full = (cnt_q >= CNT_W'(DEPTH));
  assign chk_done = chk_now || chk_bad || chk_full;
  assign ins_stop = (pos_q == '0) || cmp_le;
  assign due_hit  = (cnt_q != '0) && cmp_le && (n_q != STEP_W'(MAX_PER_STEP));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (action_e'(in_i.action))
            ACT_SUBMIT:  state_d = S_CHECK;
            ACT_SERVICE: state_d = S_SVC_RD;
            ACT_CLEAR:   state_d = S_IDLE;
            ACT_NONE:    state_d = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (!chk_done) begin
          state_d = S_INS_RD;
        end else if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: state_d = ins_stop ? S_INS_PUT : S_INS_RD;
      S_INS_PUT: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_SVC_RD:  state_d = S_SVC_CMP;
      S_SVC_CMP: begin
        if (due_hit) begin
          if (!pend_q || out_free_i) begin
            state_d = S_SVC_RD;
          end
        end else if (!pend_q || out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d     = head_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    n_d        = n_q;
    pend_d     = pend_q;
    pend_ent_d = pend_ent_q;
    rd_addr    = head_q;
    wr_en      = 1'b0;
    wr_addr    = wrap_idx(head_q, pos_q);
    wr_data    = rd_q;
    emit_o     = '{valid: 1'b0, outcome: OC_ACCEPTED, tag: tag_q, bytes: bytes_q,
                   due: due_q, last: 1'b1};
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          n_d    = '0;
          pend_d = 1'b0;
          if (action_e'(in_i.action) == ACT_CLEAR) begin
            cnt_d = '0;
          end
        end
      end
      S_CHECK: begin
        pos_d = cnt_q;
        if (chk_done && out_free_i) begin
          emit_o.valid = 1'b1;
          priority if (chk_now) begin
            emit_o.outcome = OC_NOW;
          end else if (chk_bad) begin
            emit_o.outcome = OC_BAD;
          end else begin
            emit_o.outcome = OC_FULL;
          end
        end
      end
      S_INS_RD: begin
        rd_addr = wrap_idx(head_q, pos_q - CNT_W'(1));
      end
      S_INS_CMP: begin
        if (!ins_stop) begin
          wr_en = 1'b1;
          pos_d = pos_q - CNT_W'(1);
        end
      end
      S_INS_PUT: begin
        if (out_free_i) begin
          wr_en        = 1'b1;
          wr_data      = '{due: due_q, tag: tag_q, bytes: bytes_q};
          cnt_d        = cnt_q + CNT_W'(1);
          emit_o.valid = 1'b1;
        end
      end
      S_SVC_RD: begin
      end
      S_SVC_CMP: begin
        emit_o.outcome = OC_DISPATCH;
        emit_o.tag     = pend_ent_q.tag;
        emit_o.bytes   = pend_ent_q.bytes;
        emit_o.due     = pend_ent_q.due;
        if (due_hit) begin
          if (!pend_q || out_free_i) begin
            emit_o.valid = pend_q;
            emit_o.last  = 1'b0;
            pend_ent_d   = rd_q;
            pend_d       = 1'b1;
            head_d       = wrap_idx(head_q, CNT_W'(1));
            cnt_d        = cnt_q - CNT_W'(1);
            n_d          = n_q + STEP_W'(1);
          end
        end else if (pend_q && out_free_i) begin
          emit_o.valid = 1'b1;
          pend_d       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      n_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ent_q <= pend_ent_d;
    if (in_fire) begin
      now_q   <= in_i.time_now;
      due_q   <= in_i.due_time;
      tag_q   <= in_i.command_tag;
      bytes_q <= in_i.command_bytes;
    end
  end

  // Entry ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> out_free_i)
    else $error("result issued into a busy output register");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (action_e'(in_i.action) == ACT_CLEAR)) |=> (cnt_q == '0))
    else $error("clear did not empty the queue");

  a_accept_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && (emit_o.outcome == OC_ACCEPTED))
      |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("accepted command not counted");

endmodule

@@ sv/timed_command_scheduler_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_command_scheduler_queue_top
// Sorted timer queue of commands with a registered result channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one request per transfer: submit (action 0), service at
//         time_now (action 1) or clear (action 2); action 3 is dropped.
//   out_o carries results. A submit yields exactly one result; a service
//         yields one dispatch per due entry, at most MAX_PER_STEP, earliest
//         first, with last_of_run on the final one; clear and service with
//         nothing due yield none.
// Sequencer with one shared 64-bit comparator, one ring read a cycle:
//   submit: answered from the check state when no insert is needed; an
//           insert moves up to DEPTH-1 entries, reading and comparing each.
//   service: a ring read and a compare state for each entry examined.
//   in_i.ready is high only while the sequencer is idle, so the next request
//   is taken in the cycle after the last result of the previous one is issued.
// Reset: the queue is empty and no result is pending; there is no clearing
// pass. A stalled out_o holds its result; the sequencer waits at the next
// result it wants to issue and resumes when the register frees.
// ----------------------------------------------------------------------------
module timed_command_scheduler_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  scq_in_if.sink    in_i,
  scq_out_if.source out_o
);
  import scq_pkg::*;

  result_t emit;
  result_t out_q;
  logic    out_valid_q;
  logic    out_free;

  assign out_free = !out_valid_q || out_o.ready;

  scq_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .emit_o     (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.outcome      = out_q.outcome;
  assign out_o.out_tag      = out_q.tag;
  assign out_o.out_bytes    = out_q.bytes;
  assign out_o.out_due_time = out_q.due;
  assign out_o.last_of_run  = out_q.last;

endmodule
